@@ sv/hlsg_pkg.sv @@
// Shared types, constants and helpers of the H-bot line step generator.
package hlsg_pkg;

  // Coordinate width of the stored position; the ports keep fixed field widths.
  localparam int COORD_BITS_DEF = 14;
  localparam int FIELD_W        = 14;
  localparam int FUNC_W         = 3;
  localparam int HALF_W         = 16;
  localparam logic [HALF_W-1:0] HALF_RESET = 16'd700;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // Bit positions of the result fields in out_tdata.
  localparam int OB_TOP_STEP    = 0;
  localparam int OB_STEP_BOTTOM = 1;
  localparam int OB_DIR_TOP     = 2;
  localparam int OB_DIR_BOTTOM  = 3;
  localparam int OB_ENABLE_N    = 4;
  localparam int OB_BUSY        = 5;
  localparam int OB_STATUS      = 6;
  localparam int OB_POS_X       = 7;
  localparam int OB_POS_Y       = OB_POS_X + FIELD_W;

  // Function codes on the input channel.
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_TRAVEL  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_HOME    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ENABLE  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DISABLE = 3'd4;

  // Direction codes of a line step, combined for diagonals.
  localparam logic [3:0] MV_UP    = 4'd1;
  localparam logic [3:0] MV_RIGHT = 4'd2;
  localparam logic [3:0] MV_DOWN  = 4'd4;
  localparam logic [3:0] MV_LEFT  = 4'd8;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_TRAVEL,
    CMD_HOME,
    CMD_ENABLE,
    CMD_DISABLE,
    CMD_NOP
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW
  } phase_t;

  // One classified command waiting between front and back.
  typedef struct packed {
    cmd_t               cmd;
    logic [FIELD_W-1:0] tx;
    logic [FIELD_W-1:0] ty;
  } cmd_item_t;

  // One result item.
  typedef struct packed {
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] pos_x;
    logic               status;
    logic               busy;
    logic               enable_n;
    logic               dir_bottom;
    logic               dir_top;
    logic               step_bottom;
    logic               top_step;
  } res_t;

  // Direction levels (bit 0 top, bit 1 bottom) and motor mask of a step.
  typedef struct packed {
    logic [1:0] dir;
    logic [1:0] mask;
  } drive_t;

  // Map a direction code onto the two belt motors. A diagonal turns one motor
  // and leaves the other motor's direction bit alone.
  function automatic drive_t motion_apply(input logic [3:0] code, input logic [1:0] dir);
    drive_t d;
    logic   up, rt, dn, lf;
    up = code[0];
    rt = code[1];
    dn = code[2];
    lf = code[3];
    d.dir  = dir;
    d.mask = 2'b11;
    if ((up || dn) && (rt || lf)) begin
      if (rt ^ dn) begin
        d.mask = 2'b01;
        d.dir  = {dir[1], dn};
      end else begin
        d.mask = 2'b10;
        d.dir  = {dn, dir[0]};
      end
    end else if (up) begin
      d.dir = 2'b00;
    end else if (dn) begin
      d.dir = 2'b11;
    end else if (lf) begin
      d.dir = 2'b01;
    end else begin
      d.dir = 2'b10;
    end
    return d;
  endfunction

endpackage

@@ sv/hlsg_front.sv @@
// Front end: input handshake and decoding of the function code.
module hlsg_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hlsg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [hlsg_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             q_full,
  output logic                             q_push,
  output hlsg_pkg::cmd_item_t              q_item
);

  logic [hlsg_pkg::FUNC_W-1:0] func;

  assign func      = in_tuser[hlsg_pkg::FUNC_W-1:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.tx = in_tdata[hlsg_pkg::FIELD_W-1:0];
    q_item.ty = in_tdata[2*hlsg_pkg::FIELD_W-1:hlsg_pkg::FIELD_W];
    unique case (func)
      hlsg_pkg::FUNC_TICK:    q_item.cmd = hlsg_pkg::CMD_TICK;
      hlsg_pkg::FUNC_TRAVEL:  q_item.cmd = hlsg_pkg::CMD_TRAVEL;
      hlsg_pkg::FUNC_HOME:    q_item.cmd = hlsg_pkg::CMD_HOME;
      hlsg_pkg::FUNC_ENABLE:  q_item.cmd = hlsg_pkg::CMD_ENABLE;
      hlsg_pkg::FUNC_DISABLE: q_item.cmd = hlsg_pkg::CMD_DISABLE;
      default:                q_item.cmd = hlsg_pkg::CMD_NOP;
    endcase
  end

endmodule

@@ sv/hlsg_queue.sv @@
// Two-entry command queue between the front and the back.
module hlsg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hlsg_pkg::cmd_item_t push_item,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output hlsg_pkg::cmd_item_t head
);

  hlsg_pkg::cmd_item_t entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/hlsg_back.sv @@
// Back end: line setup, step pulse timing, position state and result register.
module hlsg_back #(
  parameter int COORD_BITS = hlsg_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hlsg_pkg::HALF_W-1:0]   cfg_wdata,
  input  logic                          q_valid,
  input  hlsg_pkg::cmd_item_t           q_item,
  output logic                          q_pop,
  output logic                          res_valid,
  input  logic                          res_ready,
  output hlsg_pkg::res_t                res
);

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 3;

  logic [hlsg_pkg::HALF_W-1:0] half_r, half_ticks;

  logic [C-1:0]          cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [C-1:0]          goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  logic [C-1:0]          steps_r, steps_nxt, steps_dec;
  logic signed [E-1:0]   err_r, err_nxt;
  logic [C:0]            s_inc_r, s_inc_nxt;
  logic signed [E-1:0]   d_inc_r, d_inc_nxt;
  logic [3:0]            d_mot_r, d_mot_nxt, s_mot_r, s_mot_nxt;
  logic [hlsg_pkg::HALF_W-1:0] ticks_r, ticks_nxt;
  hlsg_pkg::phase_t      phase_r, phase_nxt;
  logic [1:0]            dir_r, dir_nxt, mask_r, mask_nxt;
  logic                  drv_on_r, drv_on_nxt;
  logic                  out_valid_r;
  hlsg_pkg::res_t        res_r, res_nxt;

  logic                fire, busy, status;
  logic [C-1:0]        tx, ty, ax, ay, lng, sht;
  logic                neg_x, neg_y, steep;
  logic [3:0]          xc, yc, t_dmot, t_smot;
  logic [C:0]          t_sinc;
  logic signed [E-1:0] t_le0, t_dinc;
  logic                travel;
  logic signed [E-1:0] bs_err, bs_dinc, bs_err_new;
  logic [C:0]          bs_sinc;
  logic [3:0]          bs_dmot, bs_smot;
  logic                bs_diag;
  hlsg_pkg::drive_t    bs_drive;

  assign fire       = q_valid && (!out_valid_r || res_ready);
  assign q_pop      = fire;
  assign res_valid  = out_valid_r;
  assign res        = res_r;
  assign half_ticks = (half_r == '0) ? {{(hlsg_pkg::HALF_W-1){1'b0}}, 1'b1} : half_r;
  assign busy       = (phase_r != hlsg_pkg::PH_IDLE);

  // Line setup: octant, major and minor axis, initial error and increments.
  always_comb begin
    tx     = C'(q_item.tx);
    ty     = C'(q_item.ty);
    neg_x  = tx < cur_x_r;
    neg_y  = ty < cur_y_r;
    ax     = neg_x ? (cur_x_r - tx) : (tx - cur_x_r);
    ay     = neg_y ? (cur_y_r - ty) : (ty - cur_y_r);
    xc     = neg_x ? hlsg_pkg::MV_LEFT : hlsg_pkg::MV_RIGHT;
    yc     = neg_y ? hlsg_pkg::MV_DOWN : hlsg_pkg::MV_UP;
    steep  = ay > ax;
    lng    = steep ? ay : ax;
    sht    = steep ? ax : ay;
    t_dmot = xc | yc;
    t_smot = steep ? yc : xc;
    t_sinc = {sht, 1'b0};
    t_le0  = $signed({2'b00, t_sinc}) - $signed({3'b000, lng});
    t_dinc = t_le0 - $signed({3'b000, lng});
  end

  // One Bresenham step, shared by line setup and by the end of a low level.
  always_comb begin
    travel     = (q_item.cmd == hlsg_pkg::CMD_TRAVEL);
    bs_err     = travel ? t_le0  : err_r;
    bs_dinc    = travel ? t_dinc : d_inc_r;
    bs_sinc    = travel ? t_sinc : s_inc_r;
    bs_dmot    = travel ? t_dmot : d_mot_r;
    bs_smot    = travel ? t_smot : s_mot_r;
    bs_diag    = !bs_err[E-1];
    bs_err_new = bs_err + (bs_diag ? bs_dinc : $signed({2'b00, bs_sinc}));
    bs_drive   = hlsg_pkg::motion_apply(bs_diag ? bs_dmot : bs_smot, dir_r);
    steps_dec  = (steps_r != '0) ? steps_r - 1'b1 : steps_r;
  end

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    goal_x_nxt = goal_x_r;
    goal_y_nxt = goal_y_r;
    steps_nxt  = steps_r;
    err_nxt    = err_r;
    s_inc_nxt  = s_inc_r;
    d_inc_nxt  = d_inc_r;
    d_mot_nxt  = d_mot_r;
    s_mot_nxt  = s_mot_r;
    ticks_nxt  = ticks_r;
    phase_nxt  = phase_r;
    dir_nxt    = dir_r;
    mask_nxt   = mask_r;
    drv_on_nxt = drv_on_r;
    status     = 1'b0;
    if (fire) begin
      unique case (q_item.cmd)
        hlsg_pkg::CMD_TICK: begin
          if (busy) begin
            if (ticks_r > {{(hlsg_pkg::HALF_W-1){1'b0}}, 1'b1}) begin
              ticks_nxt = ticks_r - 1'b1;
            end else if (phase_r == hlsg_pkg::PH_HIGH) begin
              phase_nxt = hlsg_pkg::PH_LOW;
              ticks_nxt = half_ticks;
            end else begin
              steps_nxt = steps_dec;
              if (steps_dec == '0) begin
                cur_x_nxt = goal_x_r;
                cur_y_nxt = goal_y_r;
                phase_nxt = hlsg_pkg::PH_IDLE;
                ticks_nxt = '0;
                mask_nxt  = 2'b00;
              end else begin
                err_nxt   = bs_err_new;
                dir_nxt   = bs_drive.dir;
                mask_nxt  = bs_drive.mask;
                phase_nxt = hlsg_pkg::PH_HIGH;
                ticks_nxt = half_ticks;
              end
            end
          end
        end
        hlsg_pkg::CMD_TRAVEL: begin
          if (busy) begin
            status = 1'b1;
          end else begin
            d_mot_nxt  = t_dmot;
            s_mot_nxt  = t_smot;
            s_inc_nxt  = t_sinc;
            d_inc_nxt  = t_dinc;
            steps_nxt  = lng;
            goal_x_nxt = tx;
            goal_y_nxt = ty;
            if (lng == '0) begin
              // Zero-length line: commit at once, nothing to step.
              err_nxt   = t_le0;
              cur_x_nxt = tx;
              cur_y_nxt = ty;
              phase_nxt = hlsg_pkg::PH_IDLE;
              mask_nxt  = 2'b00;
            end else begin
              err_nxt   = bs_err_new;
              dir_nxt   = bs_drive.dir;
              mask_nxt  = bs_drive.mask;
              phase_nxt = hlsg_pkg::PH_HIGH;
              ticks_nxt = half_ticks;
            end
          end
        end
        hlsg_pkg::CMD_HOME: begin
          if (busy) begin
            status = 1'b1;
          end else begin
            drv_on_nxt = 1'b0;
            cur_x_nxt  = '0;
            cur_y_nxt  = '0;
          end
        end
        hlsg_pkg::CMD_ENABLE:  drv_on_nxt = 1'b1;
        hlsg_pkg::CMD_DISABLE: drv_on_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_nxt.top_step    = (phase_nxt == hlsg_pkg::PH_HIGH) && mask_nxt[0];
    res_nxt.step_bottom = (phase_nxt == hlsg_pkg::PH_HIGH) && mask_nxt[1];
    res_nxt.dir_top     = dir_nxt[0];
    res_nxt.dir_bottom  = dir_nxt[1];
    res_nxt.enable_n    = !drv_on_nxt;
    res_nxt.busy        = (phase_nxt != hlsg_pkg::PH_IDLE);
    res_nxt.status      = status;
    res_nxt.pos_x       = hlsg_pkg::FIELD_W'(cur_x_nxt);
    res_nxt.pos_y       = hlsg_pkg::FIELD_W'(cur_y_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= hlsg_pkg::HALF_RESET;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      steps_r     <= '0;
      err_r       <= '0;
      s_inc_r     <= '0;
      d_inc_r     <= '0;
      d_mot_r     <= '0;
      s_mot_r     <= '0;
      ticks_r     <= '0;
      phase_r     <= hlsg_pkg::PH_IDLE;
      dir_r       <= 2'b00;
      mask_r      <= 2'b00;
      drv_on_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_r <= cfg_wdata;
      end
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      goal_x_r    <= goal_x_nxt;
      goal_y_r    <= goal_y_nxt;
      steps_r     <= steps_nxt;
      err_r       <= err_nxt;
      s_inc_r     <= s_inc_nxt;
      d_inc_r     <= d_inc_nxt;
      d_mot_r     <= d_mot_nxt;
      s_mot_r     <= s_mot_nxt;
      ticks_r     <= ticks_nxt;
      phase_r     <= phase_nxt;
      dir_r       <= dir_nxt;
      mask_r      <= mask_nxt;
      drv_on_r    <= drv_on_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ sv/hbot_line_step_generator_unit.sv @@
// Top level of the H-bot line step generator.
//
// The input stream carries commands: in_tuser holds the function code (tick,
// travel, home, enable drivers, disable drivers) and in_tdata the absolute
// travel target. Every accepted command produces exactly one result transfer
// on the output stream, which reports the step and direction levels of both
// belt motors, the active-low driver enable, the busy flag, the command
// status and the committed position.
// A travel draws a Bresenham line from the committed position; ticks then
// play each step out as a high level and a low level of step_half_period
// ticks each. The half period is written through cfg_we and cfg_wdata.
// The front decodes each command into a two-entry queue, and the back takes
// it from the queue head, executes it and loads the output register.
// Throughput is one command per cycle while the receiver takes results; the
// back's state update (one Bresenham add per step) sets that figure.
// When the receiver stalls, the output register holds its result, the back
// stops draining the queue and in_tready falls once both queue entries fill.
// Reset (rst_n low at a clock edge) zeroes the position, stops any line,
// disables the drivers, empties the queue and sets the half period to 700.
module hbot_line_step_generator_unit #(
  parameter int COORD_BITS = hlsg_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration: step_half_period.
  input  logic                             cfg_we,
  input  logic [hlsg_pkg::HALF_W-1:0]      cfg_wdata,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [13:0] target_x, [27:14] target_y, zero padded.
  input  logic [hlsg_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] func, zero padded.
  input  logic [hlsg_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] top_step, [1] step_bottom, [2] dir_top, [3] dir_bottom, [4] enable_n,
  // [5] busy_res, [6] status, [20:7] pos_x, [34:21] pos_y, zero padded.
  output logic [hlsg_pkg::OUT_TDATA_W-1:0] out_tdata
);

  hlsg_pkg::cmd_item_t front_item, head_item;
  hlsg_pkg::res_t      res;
  logic                q_push, q_pop, q_full, q_valid;

  hlsg_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (front_item)
  );

  hlsg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head_item)
  );

  hlsg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result fields, lowest field first.
  always_comb begin
    out_tdata = '0;
    out_tdata[hlsg_pkg::OB_TOP_STEP]    = res.top_step;
    out_tdata[hlsg_pkg::OB_STEP_BOTTOM] = res.step_bottom;
    out_tdata[hlsg_pkg::OB_DIR_TOP]     = res.dir_top;
    out_tdata[hlsg_pkg::OB_DIR_BOTTOM]  = res.dir_bottom;
    out_tdata[hlsg_pkg::OB_ENABLE_N]    = res.enable_n;
    out_tdata[hlsg_pkg::OB_BUSY]        = res.busy;
    out_tdata[hlsg_pkg::OB_STATUS]      = res.status;
    out_tdata[hlsg_pkg::OB_POS_X +: hlsg_pkg::FIELD_W] = res.pos_x;
    out_tdata[hlsg_pkg::OB_POS_Y +: hlsg_pkg::FIELD_W] = res.pos_y;
  end

endmodule

@@ sv/hlsg_checker.sv @@
// Port-level checks of the H-bot line step generator and their binding.
module hlsg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hlsg_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or vanished while stalled");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[hlsg_pkg::OB_TOP_STEP] || out_tdata[hlsg_pkg::OB_STEP_BOTTOM])
    |-> out_tdata[hlsg_pkg::OB_BUSY])
    else $error("step pulse high while no line is active");

  a_status_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[hlsg_pkg::OB_STATUS] |-> out_tdata[hlsg_pkg::OB_BUSY])
    else $error("command rejected although the block is idle");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind hbot_line_step_generator_unit hlsg_checker u_hlsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
